FILE: rtl/core/sle_pkg.sv
package sle_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = 5;
	localparam int POS_W    = 5;
	localparam int MODE_W   = 3;
	localparam int STAT_W   = 3;

	typedef enum logic [MODE_W-1:0] {
		MD_PUSH_BACK  = 3'd0,
		MD_PUSH_FRONT = 3'd1,
		MD_POP_BACK   = 3'd2,
		MD_POP_FRONT  = 3'd3,
		MD_INSERT     = 3'd4,
		MD_ERASE      = 3'd5,
		MD_FIND       = 3'd6,
		MD_CLEAR      = 3'd7
	} sle_mode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_RANGE    = 3'd3,
		ST_NOTFOUND = 3'd4
	} sle_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_SHIFT_UP,
		S_PLACE,
		S_POP_RD,
		S_ERASE_RD,
		S_SHIFT_DN,
		S_FIND,
		S_DONE
	} sle_state_t;

	typedef struct packed {
		sle_mode_t         mode;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] value;
	} sle_req_t;

	typedef struct packed {
		sle_status_t       status;
		logic [DATA_W-1:0] data;
		logic [CNT_W-1:0]  count;
	} sle_res_t;

endpackage

FILE: rtl/core/sle_ram.sv
module sle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/sle_engine.sv
module sle_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  sle_pkg::sle_req_t req,
	output logic              idle,
	output logic              res_valid,
	input  logic              res_ready,
	output sle_pkg::sle_res_t res
);

	sle_pkg::sle_state_t st_q, st_d;
	sle_pkg::sle_req_t   req_q;
	logic [sle_pkg::CNT_W-1:0]  len_q, len_d;
	logic                       len_en;
	logic [sle_pkg::IDX_W-1:0]  w_q, w_d;
	logic                       w_en;
	logic [sle_pkg::DATA_W-1:0] data_q, data_d;
	logic                       data_en;
	sle_pkg::sle_status_t       status_q, status_d;
	logic                       status_en;

	logic                       ram_we;
	logic [sle_pkg::IDX_W-1:0]  ram_waddr, ram_raddr;
	logic [sle_pkg::DATA_W-1:0] ram_wdata, ram_rdata;

	logic [sle_pkg::CNT_W-1:0] w_ext;
	logic full, empty, ins_bad, ins_direct, era_bad;
	logic up_last, dn_more, fd_more, er_more, hit;

	sle_ram #(
		.WIDTH (sle_pkg::DATA_W),
		.DEPTH (sle_pkg::CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign w_ext      = sle_pkg::CNT_W'(w_q);
	assign full       = len_q == sle_pkg::CNT_W'(sle_pkg::CAPACITY);
	assign empty      = len_q == '0;
	assign ins_bad    = req_q.pos > len_q;
	assign ins_direct = req_q.pos == len_q;
	assign era_bad    = req_q.pos >= len_q;
	assign up_last    = w_ext == req_q.pos + sle_pkg::CNT_W'(1);
	assign dn_more    = (w_ext + sle_pkg::CNT_W'(2)) < len_q;
	assign fd_more    = (w_ext + sle_pkg::CNT_W'(1)) < len_q;
	assign er_more    = (req_q.pos + sle_pkg::CNT_W'(1)) < len_q;
	assign hit        = ram_rdata == req_q.value;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			sle_pkg::S_IDLE: begin
				if (start) st_d = sle_pkg::S_EXEC;
			end
			sle_pkg::S_EXEC: begin
				unique case (req_q.mode)
					sle_pkg::MD_PUSH_BACK: st_d = sle_pkg::S_DONE;
					sle_pkg::MD_PUSH_FRONT, sle_pkg::MD_INSERT: begin
						if (ins_bad || full || ins_direct) st_d = sle_pkg::S_DONE;
						else st_d = sle_pkg::S_SHIFT_UP;
					end
					sle_pkg::MD_POP_BACK: begin
						if (empty) st_d = sle_pkg::S_DONE;
						else st_d = sle_pkg::S_POP_RD;
					end
					sle_pkg::MD_POP_FRONT, sle_pkg::MD_ERASE: begin
						if (empty || era_bad) st_d = sle_pkg::S_DONE;
						else st_d = sle_pkg::S_ERASE_RD;
					end
					sle_pkg::MD_FIND: begin
						if (empty) st_d = sle_pkg::S_DONE;
						else st_d = sle_pkg::S_FIND;
					end
					sle_pkg::MD_CLEAR: st_d = sle_pkg::S_DONE;
					default: st_d = sle_pkg::S_DONE;
				endcase
			end
			sle_pkg::S_SHIFT_UP: begin
				if (up_last) st_d = sle_pkg::S_PLACE;
			end
			sle_pkg::S_PLACE:  st_d = sle_pkg::S_DONE;
			sle_pkg::S_POP_RD: st_d = sle_pkg::S_DONE;
			sle_pkg::S_ERASE_RD: begin
				if (er_more) st_d = sle_pkg::S_SHIFT_DN;
				else st_d = sle_pkg::S_DONE;
			end
			sle_pkg::S_SHIFT_DN: begin
				if (!dn_more) st_d = sle_pkg::S_DONE;
			end
			sle_pkg::S_FIND: begin
				if (hit || !fd_more) st_d = sle_pkg::S_DONE;
			end
			sle_pkg::S_DONE: begin
				if (res_ready) st_d = sle_pkg::S_IDLE;
			end
			default: st_d = sle_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = req_q.pos[sle_pkg::IDX_W-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = req_q.pos[sle_pkg::IDX_W-1:0];
		len_en    = 1'b0;
		len_d     = len_q;
		w_en      = 1'b0;
		w_d       = w_q;
		data_en   = 1'b0;
		data_d    = '0;
		status_en = 1'b0;
		status_d  = sle_pkg::ST_OK;
		unique case (st_q)
			sle_pkg::S_IDLE: begin
			end
			sle_pkg::S_EXEC: begin
				data_en   = 1'b1;
				status_en = 1'b1;
				unique case (req_q.mode)
					sle_pkg::MD_PUSH_BACK: begin
						if (full) begin
							status_d = sle_pkg::ST_FULL;
						end else begin
							ram_we    = 1'b1;
							ram_waddr = len_q[sle_pkg::IDX_W-1:0];
							ram_wdata = req_q.value;
							len_en    = 1'b1;
							len_d     = len_q + sle_pkg::CNT_W'(1);
						end
					end
					sle_pkg::MD_PUSH_FRONT, sle_pkg::MD_INSERT: begin
						if (ins_bad) begin
							status_d = sle_pkg::ST_RANGE;
						end else if (full) begin
							status_d = sle_pkg::ST_FULL;
						end else if (ins_direct) begin
							ram_we    = 1'b1;
							ram_wdata = req_q.value;
							len_en    = 1'b1;
							len_d     = len_q + sle_pkg::CNT_W'(1);
						end else begin
							ram_raddr = sle_pkg::IDX_W'(len_q - sle_pkg::CNT_W'(1));
							w_en      = 1'b1;
							w_d       = len_q[sle_pkg::IDX_W-1:0];
						end
					end
					sle_pkg::MD_POP_BACK: begin
						if (empty) status_d = sle_pkg::ST_EMPTY;
						else ram_raddr = sle_pkg::IDX_W'(len_q - sle_pkg::CNT_W'(1));
					end
					sle_pkg::MD_POP_FRONT, sle_pkg::MD_ERASE: begin
						if (empty) status_d = sle_pkg::ST_EMPTY;
						else if (era_bad) status_d = sle_pkg::ST_RANGE;
					end
					sle_pkg::MD_FIND: begin
						ram_raddr = '0;
						w_en      = 1'b1;
						w_d       = '0;
						if (empty) status_d = sle_pkg::ST_NOTFOUND;
					end
					sle_pkg::MD_CLEAR: begin
						len_en = 1'b1;
						len_d  = '0;
					end
					default: begin
					end
				endcase
			end
			sle_pkg::S_SHIFT_UP: begin
				ram_we    = 1'b1;
				ram_waddr = w_q;
				ram_raddr = w_q - sle_pkg::IDX_W'(2);
				if (!up_last) begin
					w_en = 1'b1;
					w_d  = w_q - sle_pkg::IDX_W'(1);
				end
			end
			sle_pkg::S_PLACE: begin
				ram_we    = 1'b1;
				ram_wdata = req_q.value;
				len_en    = 1'b1;
				len_d     = len_q + sle_pkg::CNT_W'(1);
			end
			sle_pkg::S_POP_RD: begin
				data_en = 1'b1;
				data_d  = ram_rdata;
				len_en  = 1'b1;
				len_d   = len_q - sle_pkg::CNT_W'(1);
			end
			sle_pkg::S_ERASE_RD: begin
				data_en   = 1'b1;
				data_d    = ram_rdata;
				ram_raddr = sle_pkg::IDX_W'(req_q.pos + sle_pkg::CNT_W'(1));
				if (er_more) begin
					w_en = 1'b1;
					w_d  = req_q.pos[sle_pkg::IDX_W-1:0];
				end else begin
					len_en = 1'b1;
					len_d  = len_q - sle_pkg::CNT_W'(1);
				end
			end
			sle_pkg::S_SHIFT_DN: begin
				ram_we    = 1'b1;
				ram_waddr = w_q;
				ram_raddr = w_q + sle_pkg::IDX_W'(2);
				if (dn_more) begin
					w_en = 1'b1;
					w_d  = w_q + sle_pkg::IDX_W'(1);
				end else begin
					len_en = 1'b1;
					len_d  = len_q - sle_pkg::CNT_W'(1);
				end
			end
			sle_pkg::S_FIND: begin
				ram_raddr = w_q + sle_pkg::IDX_W'(1);
				if (hit) begin
					data_en   = 1'b1;
					data_d    = sle_pkg::DATA_W'(w_q);
					status_en = 1'b1;
					status_d  = sle_pkg::ST_OK;
				end else if (fd_more) begin
					w_en = 1'b1;
					w_d  = w_q + sle_pkg::IDX_W'(1);
				end else begin
					status_en = 1'b1;
					status_d  = sle_pkg::ST_NOTFOUND;
				end
			end
			sle_pkg::S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= sle_pkg::S_IDLE;
			len_q <= '0;
		end else begin
			st_q <= st_d;
			if (len_en) len_q <= len_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && st_q == sle_pkg::S_IDLE) begin
			req_q.mode  <= req.mode;
			req_q.value <= req.value;
			if (req.mode == sle_pkg::MD_PUSH_FRONT || req.mode == sle_pkg::MD_POP_FRONT) begin
				req_q.pos <= '0;
			end else begin
				req_q.pos <= req.pos;
			end
		end
		if (w_en)      w_q      <= w_d;
		if (data_en)   data_q   <= data_d;
		if (status_en) status_q <= status_d;
	end

	assign idle       = st_q == sle_pkg::S_IDLE;
	assign res_valid  = st_q == sle_pkg::S_DONE;
	assign res.status = status_q;
	assign res.data   = data_q;
	assign res.count  = len_q;

endmodule

FILE: rtl/core/sequential_list_engine.sv
// Bounded ordered list of up to 16 signed 32-bit words.
// Input channel (in_valid/in_ready) carries mode, position and value; the
// output channel (out_valid/out_ready) returns status, data_out and count,
// exactly one result per request, in request order.
// Insert and push front move the entries from position upward up by one
// before placing the value; erase and pop front move the entries above
// position down by one; find compares entries from index 0 until a match.
// Push back, pop back, clear and error cases move no entries.
// One request is in work at a time; the next is taken once the
// sequencer is back in idle. The entry RAM has a single read port: one
// entry is moved or compared per cycle.
// in_ready is low while a request is in work. A result waits in the output
// register while out_ready is low; a further request may be taken meanwhile
// and its result is held inside the sequencer until the register frees.
// Reset (arst_n low) empties the list and drops any pending result; entry
// contents are not cleared.
module sequential_list_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           mode,
	input  logic [4:0]           position,
	input  logic signed [31:0]   value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           status,
	output logic signed [31:0]   data_out,
	output logic [4:0]           count
);

	sle_pkg::sle_req_t req;
	sle_pkg::sle_res_t res;
	sle_pkg::sle_res_t out_q;
	logic              out_valid_q;
	logic              eng_idle;
	logic              res_valid;
	logic              res_ready;
	logic              start;

	assign req.mode  = sle_pkg::sle_mode_t'(mode);
	assign req.pos   = position;
	assign req.value = value;

	assign in_ready  = eng_idle;
	assign start     = in_valid && eng_idle;
	assign res_ready = !out_valid_q || out_ready;

	sle_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.idle      (eng_idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_q.status;
	assign data_out  = out_q.data;
	assign count     = out_q.count;

endmodule

FILE: sim/sequential_list_engine_tb.sv
import sle_pkg::*;

class list_scoreboard;
	logic [DATA_W-1:0] cells [CAPACITY];
	int unsigned       fill;
	sle_res_t          pending_results [$];
	int unsigned       errors;

	function new();
		fill = 0;
		errors = 0;
	endfunction

	function int unsigned pending();
		return pending_results.size();
	endfunction

	function void note_request(sle_mode_t md, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
		sle_res_t res;
		int unsigned i;
		res.status = ST_OK;
		res.data = '0;
		case (md)
			MD_PUSH_BACK: begin
				if (fill >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					cells[fill] = val;
					fill++;
				end
			end
			MD_PUSH_FRONT: begin
				if (fill >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					for (i = fill; i > 0; i--) cells[i] = cells[i-1];
					cells[0] = val;
					fill++;
				end
			end
			MD_POP_BACK: begin
				if (fill == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.data = cells[fill-1];
					fill--;
				end
			end
			MD_POP_FRONT: begin
				if (fill == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.data = cells[0];
					for (i = 0; i + 1 < fill; i++) cells[i] = cells[i+1];
					fill--;
				end
			end
			MD_INSERT: begin
				if (pos > fill) begin
					res.status = ST_RANGE;
				end else if (fill >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					for (i = fill; i > pos; i--) cells[i] = cells[i-1];
					cells[pos] = val;
					fill++;
				end
			end
			MD_ERASE: begin
				if (fill == 0) begin
					res.status = ST_EMPTY;
				end else if (pos >= fill) begin
					res.status = ST_RANGE;
				end else begin
					res.data = cells[pos];
					for (i = pos; i + 1 < fill; i++) cells[i] = cells[i+1];
					fill--;
				end
			end
			MD_FIND: begin
				res.status = ST_NOTFOUND;
				for (i = 0; i < fill; i++) begin
					if (cells[i] == val) begin
						res.status = ST_OK;
						res.data = DATA_W'(i);
						break;
					end
				end
			end
			default: begin
				fill = 0;
			end
		endcase
		res.count = CNT_W'(fill);
		pending_results.push_back(res);
	endfunction

	function void check_result(logic [STAT_W-1:0] st, logic [DATA_W-1:0] dat,
			logic [CNT_W-1:0] cnt);
		sle_res_t want;
		if (pending_results.size() == 0) begin
			if (errors < 10)
				$display("unexpected transfer: status %0d data %0d count %0d",
					st, $signed(dat), cnt);
			errors++;
			return;
		end
		want = pending_results.pop_front();
		if (want.status !== st || want.data !== dat || want.count !== cnt) begin
			if (errors < 10)
				$display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d (status/data/count)",
					want.status, $signed(want.data), want.count,
					st, $signed(dat), cnt);
			errors++;
		end
	endfunction
endclass

module sequential_list_engine_tb;

	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT  = 3000;
	localparam int N_RANDOM    = 1700;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [MODE_W-1:0]        mode = '0;
	logic [POS_W-1:0]         position = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [STAT_W-1:0]        status;
	logic signed [DATA_W-1:0] data_out;
	logic [CNT_W-1:0]         count;

	list_scoreboard sb;
	bit             burst = 1'b0;
	bit             hold_off = 1'b0;
	int unsigned    idle_cycles = 0;
	logic [DATA_W-1:0] pool [8];

	sequential_list_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.position  (position),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.data_out  (data_out),
		.count     (count)
	);

	always #5 clk = ~clk;

	initial begin
		sb = new();
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(status, data_out, count);
		if (in_valid && in_ready)
			sb.note_request(sle_mode_t'(mode), position, value);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		int unsigned n;
		wait (arst_n);
		forever begin
			if (hold_off) begin
				n = HOLD_CYCLES;
				hold_off = 1'b0;
			end else begin
				n = burst ? 0 : $urandom_range(0, 5);
			end
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_request(sle_mode_t md, int unsigned pos, logic [DATA_W-1:0] val);
		int unsigned gap;
		gap = burst ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		position <= pos[POS_W-1:0];
		value <= val;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		if ($urandom_range(0, 99) < 55)
			return pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	function automatic int unsigned pick_position();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, CAPACITY);
		return $urandom_range(0, (sb.fill + 1 > CAPACITY) ? CAPACITY : sb.fill + 1);
	endfunction

	task automatic run_random(int unsigned items);
		int unsigned k;
		int unsigned r;
		int unsigned grow;
		int unsigned phase_left;
		sle_mode_t   md;
		logic [DATA_W-1:0] val;
		grow = 41;
		phase_left = 0;
		for (k = 0; k < items; k++) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(40, 80);
				case ($urandom_range(0, 2))
					0: grow = 62;
					1: grow = 20;
					default: grow = 41;
				endcase
				burst = ($urandom_range(0, 3) == 0);
			end
			phase_left--;
			if (k == items / 3)
				hold_off = 1'b1;
			r = $urandom_range(0, 99);
			if (r < 2) begin
				md = MD_CLEAR;
			end else if (r < 17) begin
				md = MD_FIND;
			end else if (r < 17 + grow) begin
				case ($urandom_range(0, 2))
					0: md = MD_PUSH_BACK;
					1: md = MD_PUSH_FRONT;
					default: md = MD_INSERT;
				endcase
			end else begin
				case ($urandom_range(0, 2))
					0: md = MD_POP_BACK;
					1: md = MD_POP_FRONT;
					default: md = MD_ERASE;
				endcase
			end
			val = pick_value();
			if (md == MD_FIND && sb.fill > 0 && $urandom_range(0, 1) == 1)
				val = sb.cells[$urandom_range(0, sb.fill - 1)];
			send_request(md, pick_position(), val);
		end
		burst = 1'b0;
	endtask

	initial begin
		int unsigned j;
		pool[0] = 32'h0000_0000;
		pool[1] = 32'hFFFF_FFFF;
		pool[2] = 32'h7FFF_FFFF;
		pool[3] = 32'h8000_0000;
		pool[4] = 32'h0000_0001;
		for (j = 5; j < 8; j++) pool[j] = $urandom;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(MD_POP_BACK, 0, 32'h0);
		send_request(MD_POP_FRONT, 0, 32'h0);
		send_request(MD_ERASE, 0, 32'h0);
		send_request(MD_FIND, 0, 32'h0);
		send_request(MD_INSERT, 1, 32'h1234_5678);
		send_request(MD_INSERT, 0, 32'h7FFF_FFFF);
		send_request(MD_PUSH_BACK, 31, 32'h8000_0000);
		send_request(MD_PUSH_FRONT, 16, 32'h0000_0000);
		send_request(MD_INSERT, 3, 32'hFFFF_FFFF);
		send_request(MD_INSERT, 16, 32'h5555_AAAA);
		send_request(MD_FIND, 0, 32'hFFFF_FFFF);
		send_request(MD_FIND, 0, 32'h8000_0000);
		send_request(MD_FIND, 0, 32'h0001_2345);
		send_request(MD_ERASE, 4, 32'h0);
		send_request(MD_ERASE, 16, 32'h0);
		send_request(MD_ERASE, 1, 32'hAAAA_5555);
		send_request(MD_POP_FRONT, 0, 32'h0);
		send_request(MD_POP_BACK, 0, 32'h0);
		send_request(MD_PUSH_BACK, 0, 32'h0000_0005);
		send_request(MD_INSERT, 1, 32'hFFFF_FFFE);
		send_request(MD_CLEAR, 9, 32'h1111_1111);
		send_request(MD_POP_BACK, 0, 32'h0);
		send_request(MD_CLEAR, 0, 32'h0);

		run_random(N_RANDOM);
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (25) @(posedge clk);

		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
